### rtl/core/plst_pkg.sv
// Shared types and constants of the positional list store.
// No dependencies; imported by positional_list_store_core.
package plst_pkg;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned POS_W    = 7;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    // Packed widths of the stream words, padded to whole bytes.
    localparam int unsigned S_DATA_W = 40;
    localparam int unsigned M_DATA_W = 48;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_LIST   = 2'd2,
        KIND_UNUSED = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

endpackage

### rtl/core/positional_list_store_core.sv
// Positional list store: ordered word list with insert, delete and list operations.
// Depends on plst_pkg; holds the entry memory and the shift/list sequencer.
//
//  channel | direction | tdata (low bit up)                  | tuser | tlast
//  s_axis  | in        | position[6:0], value[38:7]          | kind  | -
//  m_axis  | out       | status[1:0], entry_count[8:2],      | -     | last
//          |           | entry_value[40:9]                   |       |
//
// Insert and delete move the entries behind the position one at a time; listing reads
// them in order. All moves go through one memory port pair (one registered read, one
// write per cycle), so a move is a read then a write.
// Reset clears the count, the sequencer and the output valid; memory contents are left as they are.
// The block takes no new word until the last result of the current one is loaded
// into the output register; a stalled m_axis holds the sequencer in its emit and list states.
module positional_list_store_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // position [6:0], value [38:7], zero pad [39]
    input  logic [plst_pkg::S_DATA_W-1:0] s_axis_tdata,
    // kind [1:0]
    input  logic [plst_pkg::KIND_W-1:0]   s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // status [1:0], entry_count [8:2], entry_value [40:9], zero pad [47:41]
    output logic [plst_pkg::M_DATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast
);
    import plst_pkg::*;

    localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_MV,
        S_INS_WR,
        S_DEL_RD,
        S_DEL_MV,
        S_EMIT,
        S_LST_RD
    } state_t;

    state_t state_reg;
    logic   lst_out_reg;     // listing: read data ready, waiting for the output slot

    logic [CW-1:0]      count_reg;
    logic [AW-1:0]      idx_reg;
    logic [AW-1:0]      posm1_reg;
    logic [VALUE_W-1:0] value_reg;
    status_t            status_reg;

    logic [VALUE_W-1:0] mem [CAPACITY];
    logic [VALUE_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    logic [AW-1:0]      wr_addr;
    logic [VALUE_W-1:0] wr_data;

    logic                m_valid_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;
    logic [VALUE_W-1:0]  m_value_reg;
    logic                m_last_reg;

    // Input fields
    kind_t              in_kind;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_value;
    logic               in_accept;
    logic               out_free;
    logic               out_load;

    logic [XW-1:0] pos_x;
    logic [XW-1:0] count_x;
    logic [XW-1:0] idx_x;
    logic          ins_pos_bad;
    logic          del_pos_bad;
    logic          is_full;

    assign in_kind   = kind_t'(s_axis_tuser);
    assign in_pos    = s_axis_tdata[POS_W-1:0];
    assign in_value  = s_axis_tdata[POS_W +: VALUE_W];
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_free  = !m_valid_reg || m_axis_tready;
    assign out_load  = out_free && ((state_reg == S_EMIT) ||
                                    ((state_reg == S_LST_RD) && lst_out_reg));

    assign pos_x   = XW'(in_pos);
    assign count_x = XW'(count_reg);
    assign idx_x   = XW'(idx_reg);

    assign ins_pos_bad = (pos_x == '0) || (pos_x > count_x + XW'(1));
    assign del_pos_bad = (pos_x == '0) || (pos_x > count_x);
    assign is_full     = (count_x >= XW'(CAPACITY));

    // Memory port control
    always_comb begin
        rd_addr = idx_reg;
        mem_we  = 1'b0;
        wr_addr = idx_reg;
        wr_data = rd_data_reg;
        case (state_reg)
            S_INS_RD: rd_addr = idx_reg - AW'(1);
            S_DEL_RD: rd_addr = idx_reg + AW'(1);
            S_INS_MV: mem_we  = 1'b1;
            S_DEL_MV: mem_we  = 1'b1;
            S_INS_WR: begin
                mem_we  = 1'b1;
                wr_addr = posm1_reg;
                wr_data = value_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            lst_out_reg <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_accept) begin
                        value_reg <= in_value;
                        posm1_reg <= AW'(pos_x - XW'(1));
                        case (in_kind)
                            KIND_INSERT: begin
                                if (ins_pos_bad) begin
                                    status_reg <= ST_INVALID;
                                    state_reg  <= S_EMIT;
                                end else if (is_full) begin
                                    status_reg <= ST_FULL;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    status_reg <= ST_OK;
                                    idx_reg    <= AW'(count_reg);
                                    // shift the tail up only if the slot is occupied
                                    state_reg  <= (count_x >= pos_x) ? S_INS_RD : S_INS_WR;
                                end
                            end
                            KIND_DELETE: begin
                                if (del_pos_bad) begin
                                    status_reg <= ST_INVALID;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    status_reg <= ST_OK;
                                    idx_reg    <= AW'(pos_x - XW'(1));
                                    if (pos_x < count_x) begin
                                        state_reg <= S_DEL_RD;
                                    end else begin
                                        count_reg <= count_reg - CW'(1);
                                        state_reg <= S_EMIT;
                                    end
                                end
                            end
                            KIND_LIST: begin
                                if (count_reg == '0) begin
                                    status_reg <= ST_EMPTY;
                                    state_reg  <= S_EMIT;
                                end else begin
                                    status_reg <= ST_OK;
                                    idx_reg    <= '0;
                                    state_reg  <= S_LST_RD;
                                end
                            end
                            default: begin
                                status_reg <= ST_INVALID;
                                state_reg  <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_INS_RD: begin
                    state_reg <= S_INS_MV;
                end
                S_INS_MV: begin
                    // entry idx-1 has moved to idx; advance downward
                    idx_reg <= idx_reg - AW'(1);
                    state_reg <= ((idx_reg - AW'(1)) > posm1_reg) ? S_INS_RD : S_INS_WR;
                end
                S_INS_WR: begin
                    count_reg <= count_reg + CW'(1);
                    state_reg <= S_EMIT;
                end
                S_DEL_RD: begin
                    state_reg <= S_DEL_MV;
                end
                S_DEL_MV: begin
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_x + XW'(2) < count_x) begin
                        state_reg <= S_DEL_RD;
                    end else begin
                        count_reg <= count_reg - CW'(1);
                        state_reg <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_status_reg <= status_reg;
                        m_count_reg  <= COUNT_W'(count_x);
                        m_value_reg  <= '0;
                        m_last_reg   <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                S_LST_RD: begin
                    // read address stays on idx, so the read data holds while stalled
                    if (!lst_out_reg) begin
                        lst_out_reg <= 1'b1;
                    end else if (out_free) begin
                        m_status_reg <= ST_OK;
                        m_count_reg  <= COUNT_W'(count_x);
                        m_value_reg  <= rd_data_reg;
                        m_last_reg   <= (idx_x + XW'(1) == count_x);
                        lst_out_reg  <= 1'b0;
                        if (idx_x + XW'(1) == count_x) begin
                            state_reg <= S_IDLE;
                        end else begin
                            idx_reg <= idx_reg + AW'(1);
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {(M_DATA_W - STATUS_W - COUNT_W - VALUE_W)'(0),
                            m_value_reg, m_count_reg, m_status_reg};

endmodule
